// ===== src/c2p_pkg.sv =====
package c2p_pkg;

	// Field widths
	localparam int COORD_WIDTH         = 16;
	localparam int ANGLE_FRACTION_BITS = 6;
	localparam int CORDIC_STEPS        = 16;
	localparam int ANGLE_WIDTH         = 9 + ANGLE_FRACTION_BITS;

	// Angle accumulator works in 2^-16 degree; x/y carry 16 guard bits
	localparam int ZBITS  = 16;
	localparam int GUARD  = 16;
	localparam int XY_W   = COORD_WIDTH + GUARD + 3;
	localparam int Z_W    = 25;
	localparam int FULL_W = 26;

	localparam int DEG90  = 90 << ZBITS;
	localparam int DEG180 = 180 << ZBITS;
	localparam int DEG360 = 360 << ZBITS;

	// Output angle rounding and wrap
	localparam int ROUND_SH    = ZBITS - ANGLE_FRACTION_BITS;
	localparam int ROUND_HALF  = 1 << (ROUND_SH - 1);
	localparam int ANGLE_WRAP  = 360 << ANGLE_FRACTION_BITS;

	// Square-root recurrence
	localparam int RAD_W = 2 * COORD_WIDTH;
	localparam int REM_W = COORD_WIDTH + 2;

	// Pipeline depth: stage 1 is the input/abs register in the top level
	localparam int ANG_DEPTH  = CORDIC_STEPS + 3;
	localparam int MAG_DEPTH  = COORD_WIDTH + 4;
	localparam int PIPE_DEPTH = (ANG_DEPTH > MAG_DEPTH) ? ANG_DEPTH : MAG_DEPTH;

	// Quadrant and axis flags of one coordinate pair
	typedef struct packed {
		logic neg_x;
		logic neg_y;
		logic x_zero;
		logic y_zero;
	} quad_t;

	// atan(2^-j) in 2^-16 degree, rounded
	function automatic logic signed [Z_W-1:0] atan_step(input logic [4:0] j);
		case (j)
			5'd0:    atan_step = Z_W'(2949120);
			5'd1:    atan_step = Z_W'(1740967);
			5'd2:    atan_step = Z_W'(919879);
			5'd3:    atan_step = Z_W'(466945);
			5'd4:    atan_step = Z_W'(234379);
			5'd5:    atan_step = Z_W'(117304);
			5'd6:    atan_step = Z_W'(58666);
			5'd7:    atan_step = Z_W'(29335);
			5'd8:    atan_step = Z_W'(14668);
			5'd9:    atan_step = Z_W'(7334);
			5'd10:   atan_step = Z_W'(3667);
			5'd11:   atan_step = Z_W'(1833);
			5'd12:   atan_step = Z_W'(917);
			5'd13:   atan_step = Z_W'(458);
			5'd14:   atan_step = Z_W'(229);
			5'd15:   atan_step = Z_W'(115);
			5'd16:   atan_step = Z_W'(57);
			5'd17:   atan_step = Z_W'(29);
			5'd18:   atan_step = Z_W'(14);
			5'd19:   atan_step = Z_W'(7);
			5'd20:   atan_step = Z_W'(4);
			5'd21:   atan_step = Z_W'(2);
			5'd22:   atan_step = Z_W'(1);
			default: atan_step = '0;
		endcase
	endfunction

endpackage

// ===== src/cartesian_to_polar_degrees.sv =====
// Cartesian to polar converter: each beat carries a signed coordinate pair and
// returns its rounded magnitude and its angle in 1/64 degree, 0 up to 360
// exclusive, counterclockwise from +x; the origin gives angle 0. One pair is
// taken every cycle unless the output is stalled with every stage full. The
// depth, PIPE_DEPTH, is set by the 16-bit square-root recurrence (one result
// bit per stage) after squaring and summing; the 16 CORDIC rotations, one per
// stage, run alongside. Bubbles are squeezed out while the output is stalled.
module cartesian_to_polar_degrees
	import c2p_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          coord_valid,
	output logic                          coord_stall,
	input  logic signed [COORD_WIDTH-1:0] coord_x,
	input  logic signed [COORD_WIDTH-1:0] coord_y,
	output logic                          polar_valid,
	input  logic                          polar_stall,
	output logic [COORD_WIDTH-1:0]        magnitude,
	output logic [ANGLE_WIDTH-1:0]        angle
);

	logic [PIPE_DEPTH:1] valid_s;
	logic [PIPE_DEPTH:1] load;
	logic [PIPE_DEPTH:1] valid_nx;

	// A stage loads when the output is not stalled, or when it or any stage downstream holds a bubble
	for (genvar k = 1; k <= PIPE_DEPTH; k++) begin : g_load
		assign load[k] = !polar_stall || !(&valid_s[PIPE_DEPTH:k]);
	end

	assign coord_stall = !load[1];
	assign polar_valid = valid_s[PIPE_DEPTH];

	assign valid_nx = ({valid_s[PIPE_DEPTH-1:1], coord_valid} & load) | (valid_s & ~load);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			valid_s <= valid_nx;
		end
	end

	// Stage 1: absolute values and quadrant flags
	logic [COORD_WIDTH-1:0] ax_s1, ay_s1;
	quad_t                  quad_s1;

	always_ff @(posedge clk) begin
		if (load[1]) begin
			ax_s1          <= coord_x[COORD_WIDTH-1] ? (~coord_x + COORD_WIDTH'(1)) : coord_x;
			ay_s1          <= coord_y[COORD_WIDTH-1] ? (~coord_y + COORD_WIDTH'(1)) : coord_y;
			quad_s1.neg_x  <= coord_x[COORD_WIDTH-1];
			quad_s1.neg_y  <= coord_y[COORD_WIDTH-1];
			quad_s1.x_zero <= (coord_x == '0);
			quad_s1.y_zero <= (coord_y == '0);
		end
	end

	c2p_cordic u_cordic (
		.clk   (clk),
		.load  (load[PIPE_DEPTH:2]),
		.ax    (ax_s1),
		.ay    (ay_s1),
		.quad  (quad_s1),
		.angle (angle)
	);

	c2p_sqrt u_sqrt (
		.clk       (clk),
		.load      (load[PIPE_DEPTH:2]),
		.ax        (ax_s1),
		.ay        (ay_s1),
		.magnitude (magnitude)
	);

	// Input is held off only when every stage is full and the output waits
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		coord_stall |-> (&valid_s))
		else $error("input stalled with a bubble in the pipeline");

	// A free output never blocks the input
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!polar_stall |-> !coord_stall)
		else $error("input stalled while output drains");

	// An accepted beat occupies stage 1 next cycle
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(coord_valid && !coord_stall) |=> valid_s[1])
		else $error("accepted beat lost at stage 1");

	// Angle stays inside one turn
	a_angle: assert property (@(posedge clk) disable iff (!arst_n)
		polar_valid |-> (angle < ANGLE_WIDTH'(ANGLE_WRAP)))
		else $error("angle out of range");

endmodule

// ===== src/c2p_cordic.sv =====
module c2p_cordic
	import c2p_pkg::*;
(
	input  logic                   clk,
	input  logic [PIPE_DEPTH:2]    load,
	input  logic [COORD_WIDTH-1:0] ax,
	input  logic [COORD_WIDTH-1:0] ay,
	input  quad_t                  quad,
	output logic [ANGLE_WIDTH-1:0] angle
);

	// Stage registers: stage j+2 holds the result of rotation j
	logic signed [XY_W-1:0]        cx_s [2:CORDIC_STEPS-1];
	logic signed [XY_W-1:0]        cy_s [2:CORDIC_STEPS];
	logic signed [Z_W-1:0]         cz_s [2:CORDIC_STEPS+1];
	quad_t                         fl_s [2:CORDIC_STEPS+1];
	logic [FULL_W-1:0]             full_s;
	logic [ANGLE_WIDTH-1:0]        ang_s [ANG_DEPTH:PIPE_DEPTH];

	logic signed [XY_W-1:0]        x_init, y_init;

	assign x_init = signed'({{(XY_W-COORD_WIDTH-GUARD){1'b0}}, ax, {GUARD{1'b0}}});
	assign y_init = signed'({{(XY_W-COORD_WIDTH-GUARD){1'b0}}, ay, {GUARD{1'b0}}});

	// Vectoring rotations, one per stage
	for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_iter
		logic signed [XY_W-1:0] y_in;
		logic signed [Z_W-1:0]  z_in, z_nx;
		quad_t                  q_in;
		logic                   y_pos, y_neg;

		if (j == 0) begin : g_src0
			assign y_in = y_init;
			assign z_in = '0;
			assign q_in = quad;
		end else begin : g_srcn
			assign y_in = cy_s[j+1];
			assign z_in = cz_s[j+1];
			assign q_in = fl_s[j+1];
		end

		assign y_neg = y_in[XY_W-1];
		assign y_pos = !y_in[XY_W-1] && (y_in != '0);

		always_comb begin
			if (y_pos) begin
				z_nx = z_in + atan_step(5'(j));
			end else if (y_neg) begin
				z_nx = z_in - atan_step(5'(j));
			end else begin
				z_nx = z_in;
			end
		end

		always_ff @(posedge clk) begin
			if (load[j+2]) begin
				cz_s[j+2] <= z_nx;
				fl_s[j+2] <= q_in;
			end
		end

		// y is needed up to the last rotation, x up to the one before
		if (j < CORDIC_STEPS - 1) begin : g_y
			logic signed [XY_W-1:0] x_in, y_nx;

			if (j == 0) begin : g_x0
				assign x_in = x_init;
			end else begin : g_xn
				assign x_in = cx_s[j+1];
			end

			always_comb begin
				if (y_pos) begin
					y_nx = y_in - (x_in >>> j);
				end else if (y_neg) begin
					y_nx = y_in + (x_in >>> j);
				end else begin
					y_nx = y_in;
				end
			end

			always_ff @(posedge clk) begin
				if (load[j+2]) begin
					cy_s[j+2] <= y_nx;
				end
			end

			if (j < CORDIC_STEPS - 2) begin : g_x
				logic signed [XY_W-1:0] x_nx;

				always_comb begin
					if (y_pos) begin
						x_nx = x_in + (y_in >>> j);
					end else if (y_neg) begin
						x_nx = x_in - (y_in >>> j);
					end else begin
						x_nx = x_in;
					end
				end

				always_ff @(posedge clk) begin
					if (load[j+2]) begin
						cx_s[j+2] <= x_nx;
					end
				end
			end
		end
	end

	// Clamp to the first quadrant, handle axes, fold to the full circle
	logic signed [Z_W-1:0] z_last;
	quad_t                 q_last;
	logic [FULL_W-1:0]     first_q, full_nx;

	assign z_last = cz_s[CORDIC_STEPS+1];
	assign q_last = fl_s[CORDIC_STEPS+1];

	always_comb begin
		if (q_last.y_zero) begin
			first_q = '0;
		end else if (q_last.x_zero) begin
			first_q = FULL_W'(DEG90);
		end else if (z_last < Z_W'(0)) begin
			first_q = '0;
		end else if (z_last > Z_W'(DEG90)) begin
			first_q = FULL_W'(DEG90);
		end else begin
			first_q = FULL_W'(z_last);
		end

		if (!q_last.neg_x && !q_last.neg_y) begin
			full_nx = first_q;
		end else if (q_last.neg_x && !q_last.neg_y) begin
			full_nx = FULL_W'(DEG180) - first_q;
		end else if (q_last.neg_x) begin
			full_nx = FULL_W'(DEG180) + first_q;
		end else begin
			full_nx = FULL_W'(DEG360) - first_q;
		end
	end

	always_ff @(posedge clk) begin
		if (load[ANG_DEPTH-1]) begin
			full_s <= full_nx;
		end
	end

	// Round half up to output units; a full turn wraps to zero
	logic [FULL_W-1:0] rounded;

	always_comb begin
		rounded = (full_s + FULL_W'(ROUND_HALF)) >> ROUND_SH;
		if (rounded >= FULL_W'(ANGLE_WRAP)) begin
			rounded = rounded - FULL_W'(ANGLE_WRAP);
		end
	end

	always_ff @(posedge clk) begin
		if (load[ANG_DEPTH]) begin
			ang_s[ANG_DEPTH] <= ANGLE_WIDTH'(rounded);
		end
	end

	// Align with the magnitude path
	for (genvar k = ANG_DEPTH + 1; k <= PIPE_DEPTH; k++) begin : g_delay
		always_ff @(posedge clk) begin
			if (load[k]) begin
				ang_s[k] <= ang_s[k-1];
			end
		end
	end

	assign angle = ang_s[PIPE_DEPTH];

endmodule

// ===== src/c2p_sqrt.sv =====
module c2p_sqrt
	import c2p_pkg::*;
(
	input  logic                   clk,
	input  logic [PIPE_DEPTH:2]    load,
	input  logic [COORD_WIDTH-1:0] ax,
	input  logic [COORD_WIDTH-1:0] ay,
	output logic [COORD_WIDTH-1:0] magnitude
);

	logic [RAD_W-1:0]       sqx_s2, sqy_s2;
	logic [RAD_W-1:0]       rad_s  [3:COORD_WIDTH+2];
	logic [REM_W-1:0]       rem_s  [4:COORD_WIDTH+3];
	logic [COORD_WIDTH-1:0] root_s [4:COORD_WIDTH+3];
	logic [COORD_WIDTH-1:0] mag_s  [MAG_DEPTH:PIPE_DEPTH];

	logic [RAD_W-1:0]       ax_ext, ay_ext;

	assign ax_ext = RAD_W'(ax);
	assign ay_ext = RAD_W'(ay);

	// Squares, then their sum
	always_ff @(posedge clk) begin
		if (load[2]) begin
			sqx_s2 <= ax_ext * ax_ext;
			sqy_s2 <= ay_ext * ay_ext;
		end
		if (load[3]) begin
			rad_s[3] <= sqx_s2 + sqy_s2;
		end
	end

	// Restoring square root, one result bit per stage
	for (genvar i = 0; i < COORD_WIDTH; i++) begin : g_bit
		logic [REM_W-1:0]       rem_in, rem_nx;
		logic [COORD_WIDTH-1:0] root_in, root_nx;
		logic [REM_W+1:0]       shifted, trial;

		if (i == 0) begin : g_src0
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_srcn
			assign rem_in  = rem_s[3+i];
			assign root_in = root_s[3+i];
		end

		assign shifted = {rem_in, rad_s[3+i][RAD_W-1-2*i -: 2]};
		assign trial   = (REM_W+2)'({root_in, 2'b01});

		always_comb begin
			if (shifted >= trial) begin
				rem_nx  = REM_W'(shifted - trial);
				root_nx = {root_in[COORD_WIDTH-2:0], 1'b1};
			end else begin
				rem_nx  = REM_W'(shifted);
				root_nx = {root_in[COORD_WIDTH-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			if (load[4+i]) begin
				rem_s[4+i]  <= rem_nx;
				root_s[4+i] <= root_nx;
			end
		end

		if (i < COORD_WIDTH - 1) begin : g_rad
			always_ff @(posedge clk) begin
				if (load[4+i]) begin
					rad_s[4+i] <= rad_s[3+i];
				end
			end
		end
	end

	// Round to nearest: up when the remainder exceeds the root
	logic [REM_W-1:0]       rem_last;
	logic [COORD_WIDTH-1:0] root_last;

	assign rem_last  = rem_s[COORD_WIDTH+3];
	assign root_last = root_s[COORD_WIDTH+3];

	always_ff @(posedge clk) begin
		if (load[MAG_DEPTH]) begin
			mag_s[MAG_DEPTH] <= root_last + COORD_WIDTH'(rem_last > REM_W'(root_last));
		end
	end

	for (genvar k = MAG_DEPTH + 1; k <= PIPE_DEPTH; k++) begin : g_delay
		always_ff @(posedge clk) begin
			if (load[k]) begin
				mag_s[k] <= mag_s[k-1];
			end
		end
	end

	assign magnitude = mag_s[PIPE_DEPTH];

endmodule

// ===== dv/cartesian_to_polar_degrees_tb.sv =====
module cartesian_to_polar_degrees_tb;
	import c2p_pkg::*;

	// Predictor precision: angle kept in 2^-16 degree, coordinates carry 16 guard bits
	localparam int     Z_FRAC     = 16;
	localparam int     XY_GUARD   = 16;
	localparam int     ROT_STEPS  = 16;
	localparam int     OUT_FRAC   = 6;
	localparam longint QTR_TURN   = longint'(90) << Z_FRAC;
	localparam longint HALF_TURN  = longint'(180) << Z_FRAC;
	localparam longint FULL_TURN  = longint'(360) << Z_FRAC;
	localparam longint OUT_TURN   = longint'(360) << OUT_FRAC;
	localparam longint ATAN_STEP [ROT_STEPS] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115
	};

	// Angles in output units that can be read off directly
	localparam int A_0   = 0;
	localparam int A_90  = 90 << OUT_FRAC;
	localparam int A_180 = 180 << OUT_FRAC;
	localparam int A_270 = 270 << OUT_FRAC;

	// Run control
	localparam int PREDICT     = -1;
	localparam int LONG_HOLD   = 80;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = PIPE_DEPTH + 10;
	localparam int PHASES      = 6;
	localparam int PHASE_PAIRS = 75;
	localparam int N_ROWS      = 22;

	typedef struct {
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
		logic [COORD_WIDTH-1:0]        mag;
		logic [ANGLE_WIDTH-1:0]        ang;
	} polar_t;

	// Directed pairs: x, y, magnitude, angle (PREDICT where the predictor decides)
	localparam int DIRECTED [N_ROWS][4] = '{
		'{0, 0, 0, A_0},
		'{100, 0, 100, A_0},
		'{0, 100, 100, A_90},
		'{-100, 0, 100, A_180},
		'{0, -100, 100, A_270},
		'{1, 0, 1, A_0},
		'{0, -1, 1, A_270},
		'{-1, 0, 1, A_180},
		'{32767, 0, 32767, A_0},
		'{-32768, 0, 32768, A_180},
		'{0, 32767, 32767, A_90},
		'{0, -32768, 32768, A_270},
		'{3, 4, PREDICT, PREDICT},
		'{1, 1, PREDICT, PREDICT},
		'{-1, -1, PREDICT, PREDICT},
		'{1, -1, PREDICT, PREDICT},
		'{-1, 1, PREDICT, PREDICT},
		'{32767, 32767, PREDICT, PREDICT},
		'{-32768, -32768, PREDICT, PREDICT},
		'{32767, -32768, PREDICT, PREDICT},
		'{32767, -1, PREDICT, PREDICT},
		'{-32768, -1, PREDICT, PREDICT}
	};
	localparam int EXTREMES [6] = '{-32768, -32767, -1, 0, 1, 32767};

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          coord_valid = 1'b0;
	logic                          coord_stall;
	logic signed [COORD_WIDTH-1:0] coord_x = '0;
	logic signed [COORD_WIDTH-1:0] coord_y = '0;
	logic                          polar_valid;
	logic                          polar_stall = 1'b0;
	logic [COORD_WIDTH-1:0]        magnitude;
	logic [ANGLE_WIDTH-1:0]        angle;

	polar_t pending_polar[$];
	polar_t oldest;
	int     errors = 0;
	int     stuck_cycles = 0;
	bit     progress;
	int     tx_idle_pct = 0;
	int     rx_idle_pct = 0;
	bit     rx_long_req = 1'b0;
	int     rx_hold_left = 0;

	cartesian_to_polar_degrees u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.coord_valid (coord_valid),
		.coord_stall (coord_stall),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.polar_valid (polar_valid),
		.polar_stall (polar_stall),
		.magnitude   (magnitude),
		.angle       (angle)
	);

	always #5 clk = ~clk;

	// Rounded magnitude and folded CORDIC angle of one pair
	function automatic polar_t polar_of(input logic signed [COORD_WIDTH-1:0] px,
			input logic signed [COORD_WIDTH-1:0] py);
		polar_t res;
		longint ax, ay, sum, root, trial;
		longint cx, cy, cz, dx, dy, first, full, ang;
		ax = px;
		ay = py;
		if (ax < 0) ax = -ax;
		if (ay < 0) ay = -ay;

		// Floor root bit by bit, then round up when the remainder exceeds the root
		sum = ax * ax + ay * ay;
		root = 0;
		for (int b = 15; b >= 0; b--) begin
			trial = root | (longint'(1) << b);
			if (trial * trial <= sum) root = trial;
		end
		if (sum - root * root > root) root++;

		// First-quadrant angle; axes are exact
		if (ay == 0) begin
			first = 0;
		end else if (ax == 0) begin
			first = QTR_TURN;
		end else begin
			cx = ax <<< XY_GUARD;
			cy = ay <<< XY_GUARD;
			cz = 0;
			for (int i = 0; i < ROT_STEPS; i++) begin
				dx = cy >>> i;
				dy = cx >>> i;
				if (cy > 0) begin
					cx += dx;
					cy -= dy;
					cz += ATAN_STEP[i];
				end else if (cy < 0) begin
					cx -= dx;
					cy += dy;
					cz -= ATAN_STEP[i];
				end
			end
			if (cz < 0) cz = 0;
			if (cz > QTR_TURN) cz = QTR_TURN;
			first = cz;
		end

		// Fold into the full circle, round half up, wrap 360 to 0
		if (px >= 0 && py >= 0) full = first;
		else if (px < 0 && py >= 0) full = HALF_TURN - first;
		else if (px < 0) full = HALF_TURN + first;
		else full = FULL_TURN - first;
		ang = (full + (longint'(1) << (Z_FRAC - OUT_FRAC - 1))) >>> (Z_FRAC - OUT_FRAC);
		if (ang >= OUT_TURN) ang -= OUT_TURN;

		res.x = px;
		res.y = py;
		res.mag = root[COORD_WIDTH-1:0];
		res.ang = ang[ANGLE_WIDTH-1:0];
		return res;
	endfunction

	task automatic report(input string what, input int got, input int want, input polar_t e);
		$display("mismatch %s: x=%0d y=%0d got %0d want %0d", what, e.x, e.y, got, want);
		errors++;
	endtask

	// One input beat, with an optional idle burst before it; called right after an edge
	task automatic send_pair(input logic signed [COORD_WIDTH-1:0] px,
			input logic signed [COORD_WIDTH-1:0] py, input int mag, input int ang);
		polar_t e;
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			coord_valid <= 1'b0;
			coord_x <= COORD_WIDTH'($urandom);
			coord_y <= COORD_WIDTH'($urandom);
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		coord_valid <= 1'b1;
		coord_x <= px;
		coord_y <= py;
		do @(posedge clk); while (coord_stall);
		e = polar_of(px, py);
		if (mag != PREDICT) begin
			e.mag = COORD_WIDTH'(mag);
			e.ang = ANGLE_WIDTH'(ang);
		end
		pending_polar.push_back(e);
	endtask

	// Random pair: mostly full range, with small, axis, extreme and near-axis mixes
	task automatic pick_pair(output logic signed [COORD_WIDTH-1:0] px,
			output logic signed [COORD_WIDTH-1:0] py);
		int kind;
		kind = $urandom_range(0, 9);
		px = COORD_WIDTH'($urandom);
		py = COORD_WIDTH'($urandom);
		case (kind)
			6: begin
				px = COORD_WIDTH'(int'($urandom_range(0, 8)) - 4);
				py = COORD_WIDTH'(int'($urandom_range(0, 8)) - 4);
			end
			7: begin
				if ($urandom_range(0, 1)) px = '0;
				else py = '0;
			end
			8: begin
				px = COORD_WIDTH'(EXTREMES[$urandom_range(0, 5)]);
				py = COORD_WIDTH'(EXTREMES[$urandom_range(0, 5)]);
			end
			9: begin
				if ($urandom_range(0, 1)) px = COORD_WIDTH'(int'($urandom_range(0, 2)) - 1);
				else py = COORD_WIDTH'(int'($urandom_range(0, 2)) - 1);
			end
			default: ;
		endcase
	endtask

	// Sender: directed table, then random phases with varying idle pressure
	initial begin
		logic signed [COORD_WIDTH-1:0] rx, ry;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_ROWS; r++)
			send_pair(COORD_WIDTH'(DIRECTED[r][0]), COORD_WIDTH'(DIRECTED[r][1]),
				DIRECTED[r][2], DIRECTED[r][3]);

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin tx_idle_pct = 30; rx_idle_pct = 30; end
				1: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_idle_pct = 20; rx_long_req = 1'b1; end
				3: begin tx_idle_pct = 40; rx_idle_pct = 10; end
				4: begin tx_idle_pct = 20; rx_idle_pct = 50; end
				default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
			endcase
			// Let the pipeline drain completely before this phase
			if (ph == 3) begin
				coord_valid <= 1'b0;
				@(posedge clk);
				while (pending_polar.size() != 0) @(posedge clk);
			end
			repeat (PHASE_PAIRS) begin
				pick_pair(rx, ry);
				send_pair(rx, ry, PREDICT, PREDICT);
			end
		end

		coord_valid <= 1'b0;
		@(posedge clk);
		while (pending_polar.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && pending_polar.size() == 0)
			$display("cartesian_to_polar_degrees_tb OK");
		else
			$display("cartesian_to_polar_degrees_tb NOT OK");
		$finish;
	end

	// Receiver: short random stall bursts, plus one long hold-off on request
	always @(posedge clk) begin
		if (rx_hold_left == 0) begin
			if (rx_long_req) begin
				rx_hold_left = LONG_HOLD;
				rx_long_req = 1'b0;
			end else if ($urandom_range(0, 99) < rx_idle_pct) begin
				rx_hold_left = $urandom_range(1, 3);
			end
		end
		polar_stall <= (rx_hold_left != 0);
		if (rx_hold_left != 0) rx_hold_left--;
	end

	// Result check against the oldest pending beat, plus a no-progress watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			progress = coord_valid && !coord_stall;
			if (polar_valid && !polar_stall) begin
				progress = 1'b1;
				if (pending_polar.size() == 0) begin
					oldest = '{x: 'x, y: 'x, mag: 'x, ang: 'x};
					report("result with nothing pending", int'(magnitude), -1, oldest);
				end else begin
					oldest = pending_polar.pop_front();
					if (magnitude !== oldest.mag)
						report("magnitude", int'(magnitude), int'(oldest.mag), oldest);
					if (angle !== oldest.ang)
						report("angle", int'(angle), int'(oldest.ang), oldest);
				end
			end
			stuck_cycles = progress ? 0 : stuck_cycles + 1;
			if (stuck_cycles >= STALL_LIMIT) begin
				$display("cartesian_to_polar_degrees_tb NOT OK");
				$finish;
			end
		end
	end

endmodule

// ===== cartesian_to_polar_degrees.f =====
src/c2p_pkg.sv
src/c2p_cordic.sv
src/c2p_sqrt.sv
src/cartesian_to_polar_degrees.sv
dv/cartesian_to_polar_degrees_tb.sv
